// ----- hw/rtl/bpfa_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap page frame allocator package
// Shared types, operation and status codes, and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bpfa_pkg;

    // Width that holds any first or last block index of a range operation.
    localparam int RNG_W = 25;

    // Field widths of the stream payloads.
    localparam int BIDX_W  = 15;
    localparam int BCNT_W  = 16;
    localparam int REGN_W  = 32;
    localparam int RBLK_W  = 15;
    localparam int RADDR_W = 27;

    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_RESERVE = 2'd2,
        OP_TEST    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init_wr;
        logic load;
        logic setup;
        logic rd;
        logic exam;
        logic step;
        logic ld_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic init_last;
        logic no_work;
        logic out_free;
        logic word_full;
        logic at_last;
        op_t  op;
    } sts_t;

endpackage

// ----- hw/rtl/bpfa_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module bpfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/bpfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences the map sweep after reset and the word-by-word read, examine
// and write-back steps of each operation.
// ----------------------------------------------------------------------------
module bpfa_ctrl
    import bpfa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output cmd_t cmd,
    input  sts_t sts
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SETUP,
        S_RD,
        S_EXAM,
        S_DONE
    } state_t;

    state_t state_reg;
    logic   exam_done;

    // The examined word ends the operation.
    always_comb
    begin
        case (sts.op)
            OP_TEST:  exam_done = 1'b1;
            OP_ALLOC: exam_done = !sts.word_full || sts.at_last;
            default:  exam_done = sts.at_last;
        endcase
    end

    // Command decode.
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_INIT:  cmd.init_wr = 1'b1;
            S_IDLE:  cmd.load    = in_valid;
            S_SETUP: cmd.setup   = 1'b1;
            S_RD:    cmd.rd      = 1'b1;
            S_EXAM:
            begin
                cmd.exam = 1'b1;
                cmd.step = !exam_done;
            end
            S_DONE:  cmd.ld_out  = sts.out_free;
            default: cmd = '0;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            unique case (state_reg)
                S_INIT:
                begin
                    if (sts.init_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_SETUP;
                    end
                end
                S_SETUP:
                begin
                    state_reg <= sts.no_work ? S_DONE : S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_EXAM;
                end
                S_EXAM:
                begin
                    state_reg <= exam_done ? S_DONE : S_RD;
                end
                S_DONE:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_INIT;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/bpfa_dp.sv -----
// ----------------------------------------------------------------------------
// Allocator datapath
// Holds the operation, the range bounds and the word pointer, builds the
// modified map word, and keeps the output register.
// ----------------------------------------------------------------------------
module bpfa_dp
    import bpfa_pkg::*;
#(
    parameter int NUM_FRAMES    = 32768,
    parameter int BLOCK_SHIFT   = 12,
    parameter int MAP_WORD_BITS = 32,
    parameter int MAP_WORDS     = (NUM_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS,
    parameter int WADDR_W       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    // Input item fields
    input  op_t                      in_op,
    input  logic [BIDX_W-1:0]        in_block_index,
    input  logic [BCNT_W-1:0]        in_block_count,
    input  logic [REGN_W-1:0]        in_region_base,
    input  logic [REGN_W-1:0]        in_region_length,
    input  logic [REGN_W-1:0]        in_region_type,
    // Map RAM
    output logic                     ram_we,
    output logic [WADDR_W-1:0]       ram_waddr,
    output logic [MAP_WORD_BITS-1:0] ram_wdata,
    output logic                     ram_re,
    output logic [WADDR_W-1:0]       ram_raddr,
    input  logic [MAP_WORD_BITS-1:0] ram_rdata,
    // Result
    output logic                     out_valid,
    input  logic                     out_ready,
    output status_t                  out_status,
    output logic [RBLK_W-1:0]        out_block,
    output logic [RADDR_W-1:0]       out_address,
    output logic                     out_used
);

    localparam int W         = MAP_WORD_BITS;
    localparam int BIT_W     = $clog2(MAP_WORD_BITS);
    localparam int IDX_W     = WADDR_W + BIT_W;
    localparam int ALLOC_LAST = MAP_WORDS * MAP_WORD_BITS - 1;

    localparam logic [RNG_W-1:0]   N_BLK  = RNG_W'(NUM_FRAMES);
    localparam logic [RNG_W-1:0]   N_LAST = RNG_W'(NUM_FRAMES - 1);
    localparam logic [WADDR_W-1:0] W_LAST = WADDR_W'(MAP_WORDS - 1);

    // Operation registers.
    op_t              op_reg;
    logic [RNG_W-1:0] first_reg;
    logic [RNG_W-1:0] last_reg;
    logic             empty_reg;
    logic             skip_reg;
    status_t          status_reg;
    logic [IDX_W-1:0] blk_reg;
    logic             used_reg;
    logic [WADDR_W-1:0] w_reg;

    // Output register.
    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [RBLK_W-1:0]  out_block_reg;
    logic [RADDR_W-1:0] out_address_reg;
    logic               out_used_reg;

    // Load-time values.
    logic [RNG_W-1:0] rel_first;
    logic [RNG_W-1:0] rel_cnt;
    logic [RNG_W-1:0] ld_first;
    logic [RNG_W-1:0] ld_cnt;
    logic [RNG_W-1:0] ld_last;
    logic             ld_empty;
    logic             ld_skip;
    status_t          ld_status;

    // Word-level values.
    logic               oob;
    logic [WADDR_W-1:0] first_word;
    logic [WADDR_W-1:0] last_word;
    logic [BIT_W-1:0]   lo_bit;
    logic [BIT_W-1:0]   hi_bit;
    logic [W-1:0]       range_mask;
    logic [W-1:0]       free_bits;
    logic [W-1:0]       low_free;
    logic [BIT_W-1:0]   low_idx;
    logic [W-1:0]       new_word;
    logic               alloc_hit;
    logic               is_range;
    logic [31:0]        blk_wide;
    logic [63:0]        addr_wide;

    // Decode of the incoming item into a block range.
    always_comb
    begin
        rel_first = RNG_W'(in_region_base >> BLOCK_SHIFT);
        rel_cnt   = RNG_W'(in_region_length >> BLOCK_SHIFT);
        ld_skip   = 1'b0;
        ld_status = ST_OK;
        case (in_op)
            OP_ALLOC:
            begin
                ld_first  = '0;
                ld_cnt    = RNG_W'(ALLOC_LAST + 1);
                ld_status = ST_FULL;
            end
            OP_RELEASE:
            begin
                ld_first = rel_first;
                ld_cnt   = rel_cnt;
                ld_skip  = (in_region_type != 32'd1);
            end
            OP_RESERVE:
            begin
                ld_first = RNG_W'(in_block_index);
                ld_cnt   = RNG_W'(in_block_count);
            end
            default:
            begin
                ld_first  = RNG_W'(in_block_index);
                ld_cnt    = RNG_W'(1);
                ld_status = (RNG_W'(in_block_index) >= N_BLK) ? ST_RANGE : ST_OK;
            end
        endcase
        ld_last  = ld_first + ld_cnt - RNG_W'(1);
        ld_empty = (ld_cnt == '0);
    end

    // Range clamp and work check, evaluated in the setup step.
    assign oob        = !empty_reg && (last_reg >= N_BLK);
    assign first_word = first_reg[BIT_W +: WADDR_W];
    assign last_word  = last_reg[BIT_W +: WADDR_W];
    assign is_range   = (op_reg == OP_RELEASE) || (op_reg == OP_RESERVE);

    // Bit mask of the range within the current word.
    always_comb
    begin
        lo_bit = (w_reg == first_word) ? first_reg[BIT_W-1:0] : '0;
        hi_bit = (w_reg == last_word) ? last_reg[BIT_W-1:0] : BIT_W'(W - 1);
        for (int j = 0; j < W; j++)
        begin
            range_mask[j] = (BIT_W'(j) >= lo_bit) && (BIT_W'(j) <= hi_bit);
        end
    end

    // Lowest free bit of the current word.
    always_comb
    begin
        free_bits = ~ram_rdata;
        low_free  = free_bits & (~free_bits + W'(1));
        low_idx   = '0;
        for (int j = 0; j < W; j++)
        begin
            if (low_free[j])
            begin
                low_idx = low_idx | BIT_W'(j);
            end
        end
    end

    assign alloc_hit = (op_reg == OP_ALLOC) && (free_bits != '0);

    // Modified word for write-back.
    always_comb
    begin
        case (op_reg)
            OP_ALLOC:   new_word = ram_rdata | low_free;
            OP_RELEASE: new_word = ram_rdata & ~range_mask;
            default:    new_word = ram_rdata | range_mask;
        endcase
    end

    // Map RAM access.
    assign ram_we    = cmd.init_wr || (cmd.exam && (alloc_hit || is_range));
    assign ram_waddr = w_reg;
    assign ram_wdata = cmd.init_wr ? {W{1'b1}} : new_word;
    assign ram_re    = cmd.rd;
    assign ram_raddr = w_reg;

    // Status to the controller.
    assign sts.init_last = (w_reg == W_LAST);
    assign sts.no_work   = skip_reg || empty_reg || (first_reg >= N_BLK);
    assign sts.out_free  = !out_valid_reg || out_ready;
    assign sts.word_full = (free_bits == '0);
    assign sts.at_last   = (w_reg == last_word);
    assign sts.op        = op_reg;

    // Word pointer: sweeps the map after reset and walks each operation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= '0;
        end
        else if (cmd.init_wr || cmd.step)
        begin
            w_reg <= w_reg + WADDR_W'(1);
        end
        else if (cmd.setup)
        begin
            w_reg <= first_word;
        end
    end

    // Operation registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_op;
            first_reg  <= ld_first;
            last_reg   <= ld_last;
            empty_reg  <= ld_empty;
            skip_reg   <= ld_skip;
            status_reg <= ld_status;
            blk_reg    <= '0;
            used_reg   <= 1'b0;
        end
        else if (cmd.setup)
        begin
            if (is_range)
            begin
                status_reg <= (!skip_reg && oob) ? ST_RANGE : ST_OK;
                if (oob)
                begin
                    last_reg <= N_LAST;
                end
            end
        end
        else if (cmd.exam)
        begin
            if (alloc_hit)
            begin
                status_reg <= ST_OK;
                blk_reg    <= {w_reg, low_idx};
            end
            if (op_reg == OP_TEST)
            begin
                used_reg <= ram_rdata[first_reg[BIT_W-1:0]];
            end
        end
    end

    assign blk_wide  = 32'(blk_reg);
    assign addr_wide = 64'(blk_reg) << BLOCK_SHIFT;

    // Output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.ld_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.ld_out)
        begin
            out_status_reg  <= status_reg;
            out_block_reg   <= blk_wide[RBLK_W-1:0];
            out_address_reg <= addr_wide[RADDR_W-1:0];
            out_used_reg    <= used_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_block   = out_block_reg;
    assign out_address = out_address_reg;
    assign out_used    = out_used_reg;

endmodule

// ----- hw/rtl/bitmap_page_frame_allocator_top.sv -----
// One item is in work at a time; each map word takes a read step and an examine
// step through the single map RAM. After reset the map is swept to all ones, one
// word a cycle, over all MAP_WORDS words (1024 by default) before the first
// transaction.
// ----------------------------------------------------------------------------
// Bitmap page frame allocator
// One used bit per physical block kept in a word RAM, with alloc, release
// region, reserve range and test operations on stream interfaces.
// MAP_WORD_BITS is a power of two.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_top
    import bpfa_pkg::*;
#(
    parameter int NUM_FRAMES    = 32768,
    parameter int BLOCK_SHIFT   = 12,
    parameter int MAP_WORD_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // block_index[14:0], block_count[30:15], region_base[62:31],
    // region_length[94:63], region_type[126:95], zero[127]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // op[1:0]
    input  logic [1:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // result_block[14:0], result_address[41:15], is_used[42], zero[47:43]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]             m_axis_tuser
);

    localparam int MAP_WORDS = (NUM_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PAD_W     = OUT_TDATA_W - RBLK_W - RADDR_W - 1;

    cmd_t cmd;
    sts_t sts;

    logic                     ram_we;
    logic [WADDR_W-1:0]       ram_waddr;
    logic [MAP_WORD_BITS-1:0] ram_wdata;
    logic                     ram_re;
    logic [WADDR_W-1:0]       ram_raddr;
    logic [MAP_WORD_BITS-1:0] ram_rdata;

    status_t            out_status;
    logic [RBLK_W-1:0]  out_block;
    logic [RADDR_W-1:0] out_address;
    logic               out_used;

    // Controller.
    bpfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Datapath with input field unpacking.
    bpfa_dp #(
        .NUM_FRAMES    (NUM_FRAMES),
        .BLOCK_SHIFT   (BLOCK_SHIFT),
        .MAP_WORD_BITS (MAP_WORD_BITS),
        .MAP_WORDS     (MAP_WORDS),
        .WADDR_W       (WADDR_W)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .in_op            (op_t'(s_axis_tuser)),
        .in_block_index   (s_axis_tdata[14:0]),
        .in_block_count   (s_axis_tdata[30:15]),
        .in_region_base   (s_axis_tdata[62:31]),
        .in_region_length (s_axis_tdata[94:63]),
        .in_region_type   (s_axis_tdata[126:95]),
        .ram_we           (ram_we),
        .ram_waddr        (ram_waddr),
        .ram_wdata        (ram_wdata),
        .ram_re           (ram_re),
        .ram_raddr        (ram_raddr),
        .ram_rdata        (ram_rdata),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_status       (out_status),
        .out_block        (out_block),
        .out_address      (out_address),
        .out_used         (out_used)
    );

    // Used-bit map.
    bpfa_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (MAP_WORDS),
        .AW    (WADDR_W)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result packing.
    assign m_axis_tdata = {{PAD_W{1'b0}}, out_used, out_address, out_block};
    assign m_axis_tuser = out_status;

`ifndef SYNTH
    // Only one item is in work: an accepted transaction blocks the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

    // A failed allocation reports no block and no address.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_FULL)) |-> (m_axis_tdata[41:0] == '0))
        else $error("failed allocation carries a block or address");

    // A set used flag only comes with a good status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[42]) |-> (m_axis_tuser == ST_OK))
        else $error("used flag with a bad status");

    // The map RAM is never read and written in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("map read and write collide");
`endif

endmodule
